// File: design/h2f_pkg.sv
// Shared types, constants and helpers for the Hartley-to-Fourier 2-D block.
`default_nettype none

package h2f_pkg;

    localparam int SIDE_BITS   = 6;
    localparam int MAX_LOG2    = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 3;
    localparam int CFG_IDX_BITS = 1;
    localparam int ADDR_BITS   = 2 * SIDE_BITS;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_LOG2 = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_LOG2 = 1'b1;

    // What the back end has to do with a request
    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_SELF  = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;

    typedef logic [SIDE_BITS-1:0]          idx_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        idx_t       row;
        idx_t       col;
        idx_t       mrow;
        idx_t       mcol;
        sample_t    coef;
        logic [1:0] kind;
    } entry_t;

    // Clamped log2 setting turned into an index mask (side - 1)
    function automatic idx_t side_mask(input logic [CFG_BITS-1:0] log2_val);
        logic [CFG_BITS-1:0] l;
        logic [SIDE_BITS:0]  side;
        begin
            l = log2_val;
            if (l < CFG_BITS'(1))
            begin
                l = CFG_BITS'(1);
            end
            if (l > CFG_BITS'(MAX_LOG2))
            begin
                l = CFG_BITS'(MAX_LOG2);
            end
            side = (SIDE_BITS+1)'(1) << l;
            side_mask = idx_t'(side - (SIDE_BITS+1)'(1));
        end
    endfunction

endpackage

`default_nettype wire

// File: design/h2f_coef_if.sv
// Input channel: one Hartley coefficient per request.
`default_nettype none

interface h2f_coef_if;
    logic              valid;
    logic              ready;
    h2f_pkg::sample_t  coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

`default_nettype wire

// File: design/h2f_result_if.sv
// Output channel: one Fourier coefficient with its position per request.
`default_nettype none

interface h2f_result_if;
    logic              valid;
    logic              ready;
    h2f_pkg::idx_t     out_row;
    h2f_pkg::idx_t     out_col;
    h2f_pkg::sample_t  real_part;
    h2f_pkg::sample_t  imag_part;
    logic              last_of_run;

    modport source (output valid, output out_row, output out_col, output real_part,
                    output imag_part, output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input real_part,
                    input imag_part, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: design/h2f_front.sv
// Front end: frame size registers, raster counters and mirror classification.
`default_nettype none

module h2f_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [h2f_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [h2f_pkg::CFG_BITS-1:0]        cfg_data,
    h2f_coef_if.sink                                 coef,
    output      logic                                push_valid,
    input  wire logic                                push_ready,
    output      h2f_pkg::entry_t                     push_entry
);

    logic [h2f_pkg::CFG_BITS-1:0] row_log2_reg, row_log2_next;
    logic [h2f_pkg::CFG_BITS-1:0] col_log2_reg, col_log2_next;
    h2f_pkg::idx_t row_cnt_reg, row_cnt_next;
    h2f_pkg::idx_t col_cnt_reg, col_cnt_next;

    h2f_pkg::idx_t row_mask, col_mask;
    h2f_pkg::idx_t r, c, mr, mc;
    logic          accept;

    assign row_mask = h2f_pkg::side_mask(row_log2_reg);
    assign col_mask = h2f_pkg::side_mask(col_log2_reg);
    assign r  = row_cnt_reg & row_mask;
    assign c  = col_cnt_reg & col_mask;
    assign mr = (~r + h2f_pkg::idx_t'(1)) & row_mask;
    assign mc = (~c + h2f_pkg::idx_t'(1)) & col_mask;

    assign accept     = coef.valid && push_ready;
    assign coef.ready = push_ready;
    assign push_valid = coef.valid;

    always_comb
    begin
        push_entry.row  = r;
        push_entry.col  = c;
        push_entry.mrow = mr;
        push_entry.mcol = mc;
        push_entry.coef = coef.coefficient;
        // mirror earlier in raster order means it is already stored
        if ((mr == r) && (mc == c))
        begin
            push_entry.kind = h2f_pkg::KIND_SELF;
        end
        else if ((mr < r) || ((mr == r) && (mc < c)))
        begin
            push_entry.kind = h2f_pkg::KIND_PAIR;
        end
        else
        begin
            push_entry.kind = h2f_pkg::KIND_STORE;
        end
    end

    always_comb
    begin
        row_log2_next = row_log2_reg;
        col_log2_next = col_log2_reg;
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                h2f_pkg::REG_ROW_LOG2: row_log2_next = cfg_data;
                h2f_pkg::REG_COL_LOG2: col_log2_next = cfg_data;
                default:               row_log2_next = row_log2_reg;
            endcase
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (accept)
        begin
            if (c == col_mask)
            begin
                col_cnt_next = '0;
                row_cnt_next = (r == row_mask) ? '0 : r + h2f_pkg::idx_t'(1);
            end
            else
            begin
                col_cnt_next = c + h2f_pkg::idx_t'(1);
                row_cnt_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_log2_reg <= h2f_pkg::CFG_BITS'(h2f_pkg::MAX_LOG2);
            col_log2_reg <= h2f_pkg::CFG_BITS'(h2f_pkg::MAX_LOG2);
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            row_log2_reg <= row_log2_next;
            col_log2_reg <= col_log2_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: design/h2f_queue.sv
// Two-entry queue between the front and back ends.
`default_nettype none

module h2f_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire h2f_pkg::entry_t  push_entry,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      h2f_pkg::entry_t  pop_entry
);

    localparam int PTR_BITS = $clog2(h2f_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(h2f_pkg::QUEUE_DEPTH + 1);

    h2f_pkg::entry_t slot_reg [h2f_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = (count_reg != CNT_BITS'(h2f_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(h2f_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(h2f_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: design/h2f_back.sv
// Back end: frame store, butterfly arithmetic and output register.
`default_nettype none

module h2f_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output      logic             pop_ready,
    input  wire h2f_pkg::entry_t  pop_entry,
    h2f_result_if.source          result
);

    localparam int SB = h2f_pkg::SAMPLE_BITS;

    h2f_pkg::sample_t frame_mem [2**h2f_pkg::ADDR_BITS];

    logic             exec_valid_reg, exec_valid_next;
    logic             exec_phase_reg, exec_phase_next;
    h2f_pkg::entry_t  exec_entry_reg;
    h2f_pkg::sample_t mirror_reg;

    logic             out_valid_reg, out_valid_next;
    h2f_pkg::idx_t    out_row_reg, out_col_reg;
    h2f_pkg::sample_t out_real_reg, out_imag_reg;
    logic             out_last_reg;

    logic             out_free, emit, done, pop;
    h2f_pkg::idx_t    emit_row, emit_col;
    h2f_pkg::sample_t emit_real, emit_imag;
    logic             emit_last;
    logic signed [SB:0] sum_hm, diff_mh, diff_hm;

    assign out_free = !out_valid_reg || result.ready;

    assign sum_hm  = {exec_entry_reg.coef[SB-1], exec_entry_reg.coef}
                   + {mirror_reg[SB-1], mirror_reg};
    assign diff_mh = {mirror_reg[SB-1], mirror_reg}
                   - {exec_entry_reg.coef[SB-1], exec_entry_reg.coef};
    assign diff_hm = {exec_entry_reg.coef[SB-1], exec_entry_reg.coef}
                   - {mirror_reg[SB-1], mirror_reg};

    always_comb
    begin
        emit      = 1'b0;
        done      = 1'b0;
        emit_row  = exec_entry_reg.row;
        emit_col  = exec_entry_reg.col;
        emit_real = sum_hm[SB:1];
        emit_imag = diff_mh[SB:1];
        emit_last = 1'b0;
        if (exec_valid_reg)
        begin
            case (exec_entry_reg.kind)
                h2f_pkg::KIND_SELF:
                begin
                    emit      = out_free;
                    done      = out_free;
                    emit_real = exec_entry_reg.coef;
                    emit_imag = '0;
                    emit_last = 1'b1;
                end
                h2f_pkg::KIND_PAIR:
                begin
                    emit = out_free;
                    if (exec_phase_reg)
                    begin
                        // conjugate result for the mirror position
                        done      = out_free;
                        emit_row  = exec_entry_reg.mrow;
                        emit_col  = exec_entry_reg.mcol;
                        emit_imag = diff_hm[SB:1];
                        emit_last = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    assign pop_ready = !exec_valid_reg || done;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        exec_valid_next = exec_valid_reg;
        exec_phase_next = exec_phase_reg;
        if (pop)
        begin
            exec_valid_next = 1'b1;
            exec_phase_next = 1'b0;
        end
        else if (done)
        begin
            exec_valid_next = 1'b0;
        end
        else if (emit)
        begin
            exec_phase_next = 1'b1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            exec_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            exec_valid_reg <= exec_valid_next;
            exec_phase_reg <= exec_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            exec_entry_reg <= pop_entry;
        end
        if (emit)
        begin
            out_row_reg  <= emit_row;
            out_col_reg  <= emit_col;
            out_real_reg <= emit_real;
            out_imag_reg <= emit_imag;
            out_last_reg <= emit_last;
        end
    end

    // Store write of the new sample and mirror read share the pop cycle;
    // for a paired position the mirror lies at an earlier, already written address.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_mem[{pop_entry.row, pop_entry.col}] <= pop_entry.coef;
            mirror_reg <= frame_mem[{pop_entry.mrow, pop_entry.mcol}];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_row     = out_row_reg;
    assign result.out_col     = out_col_reg;
    assign result.real_part   = out_real_reg;
    assign result.imag_part   = out_imag_reg;
    assign result.last_of_run = out_last_reg;

endmodule

`default_nettype wire

// File: design/hartley_to_fourier_2d_unit.sv
// Top level of the streaming 2-D Hartley-to-Fourier converter.
//
// Channels: coef carries Hartley coefficients in raster order (row by row,
// columns left to right); result returns Fourier coefficients with their row
// and column. A frame is 2^row_count_log2 by 2^col_count_log2 (1..6 each).
// A coefficient whose mirror position has not arrived yet is only stored.
// A self-mirror position gives one result with a zero imaginary part. Otherwise
// two results follow: the current position, then the mirror, last_of_run set.
// Writing either size register (cfg_write_en, cfg_index, cfg_data) restarts
// the frame at row 0, column 0; do so only while the block is idle.
// Throughput: one request per cycle for store-only positions, and for self-mirror
// positions while the output register is free; a paired position holds the back
// end until both of its results have entered the single output register, one at a time.
// A two-entry queue decouples intake from the back end, so coef keeps being
// taken while a result waits. A stalled receiver holds the result steady and
// back-pressure reaches coef once the queue fills.
// Reset: sizes return to 64 x 64, counters to zero; the frame store is not
// cleared (its contents are only read after being written in the frame).
`default_nettype none

module hartley_to_fourier_2d_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [h2f_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [h2f_pkg::CFG_BITS-1:0]      cfg_data,
    h2f_coef_if.sink                               coef,
    h2f_result_if.source                           result
);

    logic            push_valid, push_ready;
    h2f_pkg::entry_t push_entry;
    logic            pop_valid, pop_ready;
    h2f_pkg::entry_t pop_entry;

    h2f_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .coef         (coef),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    h2f_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    h2f_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: design/h2f_checker.sv
// Port-level checker for the result channel, bound to the top level.
`default_nettype none

module h2f_port_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             valid,
    input wire logic             ready,
    input wire h2f_pkg::idx_t    out_row,
    input wire h2f_pkg::idx_t    out_col,
    input wire h2f_pkg::sample_t real_part,
    input wire h2f_pkg::sample_t imag_part,
    input wire logic             last_of_run
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result request dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable({out_row, out_col, real_part, imag_part, last_of_run}))
        else $error("result payload changed while stalled");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last_of_run |=> valid && last_of_run)
        else $error("mirror result did not follow the first of a pair");

    a_pair_real: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last_of_run |=> real_part == $past(real_part))
        else $error("real parts of a pair differ");

endmodule

bind hartley_to_fourier_2d_unit h2f_port_checker u_h2f_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .out_row     (result.out_row),
    .out_col     (result.out_col),
    .real_part   (result.real_part),
    .imag_part   (result.imag_part),
    .last_of_run (result.last_of_run)
);

`default_nettype wire

// File: bench/h2f_checker.sv
// Checker: predicts Fourier results from accepted Hartley requests and compares them.
module h2f_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [h2f_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [h2f_pkg::CFG_BITS-1:0]       cfg_data,
    h2f_coef_if                                coef,
    h2f_result_if                              result,
    output int                                 fail_count,
    output int                                 pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import h2f_pkg::*;

    localparam int STORE_SIDE = 1 << SIDE_BITS;

    typedef struct packed {
        idx_t    row;
        idx_t    col;
        sample_t re;
        sample_t im;
        logic    last;
    } fourier_coef_t;

    fourier_coef_t       expected_coefs[$];
    sample_t             hartley_frame [STORE_SIDE*STORE_SIDE];
    logic [CFG_BITS-1:0] rows_log2;
    logic [CFG_BITS-1:0] cols_log2;
    int unsigned         row_pos;
    int unsigned         col_pos;

    function automatic int unsigned side_of(input logic [CFG_BITS-1:0] log2_val);
        logic [CFG_BITS-1:0] l;
        l = log2_val;
        if (l < CFG_BITS'(1))
        begin
            l = CFG_BITS'(1);
        end
        if (l > CFG_BITS'(MAX_LOG2))
        begin
            l = CFG_BITS'(MAX_LOG2);
        end
        return 1 << l;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int unsigned                 rows;
        int unsigned                 cols;
        int unsigned                 mrow;
        int unsigned                 mcol;
        int unsigned                 here;
        int unsigned                 there;
        sample_t                     h;
        sample_t                     hm;
        logic signed [SAMPLE_BITS:0] even_sum;
        logic signed [SAMPLE_BITS:0] odd_diff;
        fourier_coef_t               want;
        if (!rst_n)
        begin
            rows_log2 = CFG_BITS'(MAX_LOG2);
            cols_log2 = CFG_BITS'(MAX_LOG2);
            row_pos = 0;
            col_pos = 0;
            expected_coefs.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_ROW_LOG2)
                begin
                    rows_log2 = cfg_data;
                end
                else
                begin
                    cols_log2 = cfg_data;
                end
                row_pos = 0;
                col_pos = 0;
            end

            if (coef.valid && coef.ready)
            begin
                rows = side_of(rows_log2);
                cols = side_of(cols_log2);
                mrow = (rows - row_pos) & (rows - 1);
                mcol = (cols - col_pos) & (cols - 1);
                here = row_pos * cols + col_pos;
                there = mrow * cols + mcol;
                h = coef.coefficient;
                hartley_frame[row_pos * STORE_SIDE + col_pos] = h;
                if (there == here)
                begin
                    want = '{row: idx_t'(row_pos), col: idx_t'(col_pos), re: h, im: '0,
                             last: 1'b1};
                    expected_coefs.push_back(want);
                end
                else if (there < here)
                begin
                    // mirror came earlier in this frame: emit both halves of the pair
                    hm = hartley_frame[mrow * STORE_SIDE + mcol];
                    even_sum = h + hm;
                    odd_diff = hm - h;
                    want = '{row: idx_t'(row_pos), col: idx_t'(col_pos),
                             re: even_sum[SAMPLE_BITS:1], im: odd_diff[SAMPLE_BITS:1],
                             last: 1'b0};
                    expected_coefs.push_back(want);
                    odd_diff = h - hm;
                    want = '{row: idx_t'(mrow), col: idx_t'(mcol),
                             re: even_sum[SAMPLE_BITS:1], im: odd_diff[SAMPLE_BITS:1],
                             last: 1'b1};
                    expected_coefs.push_back(want);
                end
                col_pos++;
                if (col_pos >= cols)
                begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= rows)
                    begin
                        row_pos = 0;
                    end
                end
            end

            if (result.valid && result.ready)
            begin
                if (expected_coefs.size() == 0)
                begin
                    $error("result at row %0d col %0d with nothing expected",
                           result.out_row, result.out_col);
                    fail_count++;
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    if (result.out_row !== want.row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.row, result.out_row);
                        fail_count++;
                    end
                    if (result.out_col !== want.col)
                    begin
                        $error("out_col: expected %0d, got %0d", want.col, result.out_col);
                        fail_count++;
                    end
                    if (result.real_part !== want.re)
                    begin
                        $error("real_part: expected %0d, got %0d", want.re, result.real_part);
                        fail_count++;
                    end
                    if (result.imag_part !== want.im)
                    begin
                        $error("imag_part: expected %0d, got %0d", want.im, result.imag_part);
                        fail_count++;
                    end
                    if (result.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last,
                               result.last_of_run);
                        fail_count++;
                    end
                end
            end
            pending_results = expected_coefs.size();
        end
    end

endmodule

// File: bench/tb.sv
// Bench top: drives Hartley requests and frame sizes, stalls the receiver, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import h2f_pkg::*;

    localparam int ITEM_TARGET   = 550;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 12;

    // 4 x 4 frame: selfs, store-only and pairs built from the sample extremes
    localparam sample_t FRAME_4X4 [16] = '{
        32767, 32767, -32768, 32767,
        -32768, -32768, 1, 32767,
        0, -1, -1, 0,
        32767, -32768, -2, -32768
    };
    localparam sample_t FRAME_2X2 [6] = '{
        16'sh5555, -16'sh5556, 1, -1, 16'sh00FF, 16'sh7F00
    };

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    int                      fail_count;
    int                      pending_results;
    int                      items_sent;
    int                      burst_left;
    bit                      hold_req;

    h2f_coef_if   coef_ch ();
    h2f_result_if result_ch ();

    hartley_to_fourier_2d_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .coef         (coef_ch),
        .result       (result_ch)
    );

    h2f_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .coef            (coef_ch),
        .result          (result_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int size_log2(input logic [CFG_BITS-1:0] log2_val);
        if (log2_val < CFG_BITS'(1))
        begin
            return 1;
        end
        if (log2_val > CFG_BITS'(MAX_LOG2))
        begin
            return MAX_LOG2;
        end
        return int'(log2_val);
    endfunction

    function automatic sample_t random_coefficient();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            4:       return 16'sh0001;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // bursts of requests with random gaps between them
    task automatic send_coef(input sample_t value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                coef_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        coef_ch.valid <= 1'b1;
        coef_ch.coefficient <= value;
        do @(posedge clk); while (!coef_ch.ready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // only once the block has drained; a write restarts the frame
    task automatic program_size(input logic [CFG_BITS-1:0] rows_log2,
                                input logic [CFG_BITS-1:0] cols_log2);
        coef_ch.valid <= 1'b0;
        burst_left = 0;
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_ROW_LOG2;
        cfg_data <= rows_log2;
        @(negedge clk);
        cfg_index <= REG_COL_LOG2;
        cfg_data <= cols_log2;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CFG_BITS-1:0] rl;
        logic [CFG_BITS-1:0] cl;
        int                  cells;
        int                  count;
        int                  phase;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_ROW_LOG2;
        cfg_data = '0;
        coef_ch.valid = 1'b0;
        coef_ch.coefficient = '0;
        items_sent = 0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset size is 64 x 64: columns 1 and 2 have no mirror yet
        send_coef(16'sh7FFF);
        send_coef(16'sh8000);
        send_coef(16'sh1234);

        program_size(CFG_BITS'(2), CFG_BITS'(2));
        foreach (FRAME_4X4[i])
        begin
            send_coef(FRAME_4X4[i]);
        end

        // row setting of zero clamps to two rows; every position is its own mirror
        program_size(CFG_BITS'(0), CFG_BITS'(1));
        foreach (FRAME_2X2[i])
        begin
            send_coef(FRAME_2X2[i]);
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0:
                begin
                    rl = CFG_BITS'(7);
                    cl = CFG_BITS'(7);
                    count = 70;
                end
                1:
                begin
                    rl = CFG_BITS'(0);
                    cl = CFG_BITS'(7);
                    count = 128;
                end
                2:
                begin
                    rl = CFG_BITS'(7);
                    cl = CFG_BITS'(0);
                    count = 128;
                end
                default:
                begin
                    rl = CFG_BITS'($urandom_range(0, 3));
                    cl = CFG_BITS'($urandom_range(0, 3));
                    if ($urandom_range(0, 4) == 0)
                    begin
                        rl = CFG_BITS'($urandom_range(4, 5));
                    end
                    cells = 1 << (size_log2(rl) + size_log2(cl));
                    count = (cells > 64) ? cells : cells * $urandom_range(1, 3);
                    // sometimes leave a frame unfinished before the next size
                    if ($urandom_range(0, 3) == 0)
                    begin
                        count += $urandom_range(1, cells - 1);
                    end
                end
            endcase
            if (count > ITEM_TARGET - items_sent)
            begin
                count = ITEM_TARGET - items_sent;
            end
            program_size(rl, cl);
            if (phase == 1)
            begin
                hold_req = 1'b1;
            end
            repeat (count)
            begin
                send_coef(random_coefficient());
            end
            phase++;
        end

        coef_ch.valid <= 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : result_sink
        int mode;
        int span;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long hold-off so the queue fills and the request side backs up
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(4, 40);
            repeat (span)
            begin
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= 1'b0;
                    default: result_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((coef_ch.valid && coef_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
